// ===== design/ise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants of the integer stack engine
// Operation and status codes, and the command and status structures that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;
  localparam int OP_W                = 3;
  localparam int STATUS_W            = 3;
  localparam int DATA_W              = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_DUMP = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_PEEK_EMPTY = 3'd1,
    STAT_POP_EMPTY  = 3'd2,
    STAT_SWAP_SHORT = 3'd3,
    STAT_PUSH_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_SWAP_RD2,
    S_SWAP_WR1,
    S_SWAP_WR2,
    S_DUMP
  } state_t;

  // Read address source of the storage port.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_SECOND,
    RD_NEXT
  } rd_sel_t;

  // Write address and data source of the storage port.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_SWAP_TOP,
    WR_SWAP_SECOND
  } wr_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    fill_inc;
    logic    fill_dec;
    logic    cursor_load;
    logic    cursor_dec;
    logic    hold_load;
    logic    res_load;
    status_t res_status;
    logic    res_with_value;
    logic    res_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic short_stack;
    logic cursor_zero;
  } dp_status_t;

endpackage

// ===== design/integer_stack_engine.sv =====
`timescale 1ns / 1ps
// Push, pop, error results and an empty dump are decided in the transfer cycle and their
// result is registered, so such items may follow back to back. Peek steps through S_PEEK
// and swap through S_SWAP_RD2, S_SWAP_WR1 and S_SWAP_WR2, set by the registered read of the
// single storage port. A dump of N entries gives N results on consecutive cycles, one per
// S_DUMP state, and keeps busy high until the last. The receiver cannot stall the results.
// Reset empties the stack (fill count zero) and idles the sequencer; storage is not cleared.
// ----------------------------------------------------------------------------
// integer_stack_engine: bounded LIFO stack of signed 32-bit integers
// Executes push, dump, peek, pop and swap operations with status results.
// ----------------------------------------------------------------------------
module integer_stack_engine #(
  parameter int STACK_DEPTH = ise_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ise_pkg::OP_W-1:0]          op,
  input  logic signed [ise_pkg::DATA_W-1:0] push_value,
  output logic                              strobe,
  output logic [ise_pkg::STATUS_W-1:0]      status,
  output logic                              has_value,
  output logic signed [ise_pkg::DATA_W-1:0] result_value,
  output logic                              last
);

  // The controller decodes each operation against the stack status and
  // issues one command word per cycle; the datapath owns all storage.
  ise_pkg::dp_cmd_t    cmd;
  ise_pkg::dp_status_t dp_status;

  // The sequencer drives busy itself: it is low only while idle, so a
  // transfer is taken whenever start is high in an idle cycle. Results are
  // registered, so a new transfer can be taken while the previous result is
  // still on the result ports.
  ise_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath holds the entries, the fill count, the dump cursor and the
  // result registers, and raises strobe for exactly one cycle per result.
  ise_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .push_value   (push_value),
    .strobe       (strobe),
    .status       (status),
    .has_value    (has_value),
    .result_value (result_value),
    .last         (last)
  );

endmodule

// ===== design/ise_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_datapath: storage, fill count and result registers
// Holds the stack in a single-port-style memory with a registered read, the
// fill count, the dump cursor, a swap holding register and the result port.
// ----------------------------------------------------------------------------
module ise_datapath #(
  parameter int STACK_DEPTH = ise_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ise_pkg::dp_cmd_t                  cmd,
  output ise_pkg::dp_status_t               dp_status,
  input  logic signed [ise_pkg::DATA_W-1:0] push_value,
  output logic                              strobe,
  output logic [ise_pkg::STATUS_W-1:0]      status,
  output logic                              has_value,
  output logic signed [ise_pkg::DATA_W-1:0] result_value,
  output logic                              last
);

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);

  logic [ise_pkg::DATA_W-1:0] mem [STACK_DEPTH];
  logic [ise_pkg::DATA_W-1:0] rd_data;
  logic [ise_pkg::DATA_W-1:0] hold;
  logic [FILL_W-1:0]          fill_count;
  logic [FILL_W-1:0]          fill_count_next;
  logic [ADDR_W-1:0]          cursor;
  logic [FILL_W-1:0]          top_idx;
  logic [FILL_W-1:0]          second_idx;
  logic [ADDR_W-1:0]          top_addr;
  logic [ADDR_W-1:0]          second_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ise_pkg::DATA_W-1:0] wr_data;
  logic                       rd_en;
  logic                       wr_en;

  assign top_idx     = fill_count - FILL_W'(1);
  assign second_idx  = fill_count - FILL_W'(2);
  assign top_addr    = top_idx[ADDR_W-1:0];
  assign second_addr = second_idx[ADDR_W-1:0];

  assign dp_status.empty       = (fill_count == '0);
  assign dp_status.full        = (fill_count == FILL_W'(STACK_DEPTH));
  assign dp_status.short_stack = (fill_count < FILL_W'(2));
  assign dp_status.cursor_zero = (cursor == '0);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = top_addr;
    unique case (cmd.rd_sel)
      ise_pkg::RD_NONE:   rd_en   = 1'b0;
      ise_pkg::RD_TOP:    rd_addr = top_addr;
      ise_pkg::RD_SECOND: rd_addr = second_addr;
      ise_pkg::RD_NEXT:   rd_addr = cursor - ADDR_W'(1);
      default:            rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = top_addr;
    wr_data = rd_data;
    unique case (cmd.wr_sel)
      ise_pkg::WR_NONE: wr_en = 1'b0;
      ise_pkg::WR_PUSH: begin
        wr_addr = fill_count[ADDR_W-1:0];
        wr_data = push_value;
      end
      ise_pkg::WR_SWAP_TOP: begin
        wr_addr = top_addr;
        wr_data = rd_data;
      end
      ise_pkg::WR_SWAP_SECOND: begin
        wr_addr = second_addr;
        wr_data = hold;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (cmd.fill_inc) begin
      fill_count_next = fill_count + FILL_W'(1);
    end else if (cmd.fill_dec) begin
      fill_count_next = fill_count - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      strobe     <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      strobe     <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cursor_load) begin
      cursor <= top_addr;
    end else if (cmd.cursor_dec) begin
      cursor <= cursor - ADDR_W'(1);
    end
    if (cmd.hold_load) begin
      hold <= rd_data;
    end
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      has_value    <= cmd.res_with_value;
      result_value <= cmd.res_with_value ? rd_data : '0;
      last         <= cmd.res_last;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(STACK_DEPTH))
    else $error("fill count beyond stack depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_sel == ise_pkg::WR_PUSH |-> !dp_status.full && cmd.fill_inc)
    else $error("push written into a full stack");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_dec |=> fill_count == $past(fill_count) - FILL_W'(1))
    else $error("pop did not shrink the stack by one");

endmodule

// ===== design/ise_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_controller: operation sequencer of the integer stack engine
// Decodes each operation and steps the datapath through peek, swap and dump.
// ----------------------------------------------------------------------------
module ise_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ise_pkg::OP_W-1:0]       op,
  input  ise_pkg::dp_status_t            dp_status,
  output ise_pkg::dp_cmd_t               cmd,
  output logic                           busy
);

  ise_pkg::state_t state;
  ise_pkg::state_t state_next;
  logic            accept;

  assign accept = start && (state == ise_pkg::S_IDLE);
  assign busy   = (state != ise_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ise_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ise_pkg::S_IDLE: begin
        if (accept) begin
          if (op == ise_pkg::OP_PEEK && !dp_status.empty) begin
            state_next = ise_pkg::S_PEEK;
          end else if (op == ise_pkg::OP_SWAP && !dp_status.short_stack) begin
            state_next = ise_pkg::S_SWAP_RD2;
          end else if (op == ise_pkg::OP_DUMP && !dp_status.empty) begin
            state_next = ise_pkg::S_DUMP;
          end
        end
      end
      ise_pkg::S_PEEK:     state_next = ise_pkg::S_IDLE;
      ise_pkg::S_SWAP_RD2: state_next = ise_pkg::S_SWAP_WR1;
      ise_pkg::S_SWAP_WR1: state_next = ise_pkg::S_SWAP_WR2;
      ise_pkg::S_SWAP_WR2: state_next = ise_pkg::S_IDLE;
      ise_pkg::S_DUMP: begin
        if (dp_status.cursor_zero) begin
          state_next = ise_pkg::S_IDLE;
        end
      end
      default: state_next = ise_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.rd_sel         = ise_pkg::RD_NONE;
    cmd.wr_sel         = ise_pkg::WR_NONE;
    cmd.fill_inc       = 1'b0;
    cmd.fill_dec       = 1'b0;
    cmd.cursor_load    = 1'b0;
    cmd.cursor_dec     = 1'b0;
    cmd.hold_load      = 1'b0;
    cmd.res_load       = 1'b0;
    cmd.res_status     = ise_pkg::STAT_OK;
    cmd.res_with_value = 1'b0;
    cmd.res_last       = 1'b1;
    unique case (state)
      ise_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            ise_pkg::OP_PUSH: begin
              cmd.res_load = 1'b1;
              if (dp_status.full) begin
                cmd.res_status = ise_pkg::STAT_PUSH_FULL;
              end else begin
                cmd.wr_sel   = ise_pkg::WR_PUSH;
                cmd.fill_inc = 1'b1;
              end
            end
            ise_pkg::OP_DUMP: begin
              if (dp_status.empty) begin
                cmd.res_load = 1'b1;
              end else begin
                cmd.rd_sel      = ise_pkg::RD_TOP;
                cmd.cursor_load = 1'b1;
              end
            end
            ise_pkg::OP_PEEK: begin
              if (dp_status.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ise_pkg::STAT_PEEK_EMPTY;
              end else begin
                cmd.rd_sel = ise_pkg::RD_TOP;
              end
            end
            ise_pkg::OP_POP: begin
              cmd.res_load = 1'b1;
              if (dp_status.empty) begin
                cmd.res_status = ise_pkg::STAT_POP_EMPTY;
              end else begin
                cmd.fill_dec = 1'b1;
              end
            end
            ise_pkg::OP_SWAP: begin
              if (dp_status.short_stack) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ise_pkg::STAT_SWAP_SHORT;
              end else begin
                cmd.rd_sel = ise_pkg::RD_TOP;
              end
            end
            default: cmd.res_load = 1'b1;
          endcase
        end
      end
      ise_pkg::S_PEEK: begin
        cmd.res_load       = 1'b1;
        cmd.res_with_value = 1'b1;
      end
      ise_pkg::S_SWAP_RD2: begin
        cmd.rd_sel    = ise_pkg::RD_SECOND;
        cmd.hold_load = 1'b1;
      end
      ise_pkg::S_SWAP_WR1: begin
        cmd.wr_sel = ise_pkg::WR_SWAP_TOP;
      end
      ise_pkg::S_SWAP_WR2: begin
        cmd.wr_sel   = ise_pkg::WR_SWAP_SECOND;
        cmd.res_load = 1'b1;
      end
      ise_pkg::S_DUMP: begin
        cmd.res_load       = 1'b1;
        cmd.res_with_value = 1'b1;
        cmd.res_last       = dp_status.cursor_zero;
        if (!dp_status.cursor_zero) begin
          cmd.rd_sel     = ise_pkg::RD_NEXT;
          cmd.cursor_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_swap_sequence: assert property (@(posedge clk) disable iff (rst)
    state == ise_pkg::S_SWAP_RD2 |=> state == ise_pkg::S_SWAP_WR1 ##1
    state == ise_pkg::S_SWAP_WR2 ##1 state == ise_pkg::S_IDLE)
    else $error("swap sequence broken");

  a_dump_continues: assert property (@(posedge clk) disable iff (rst)
    state == ise_pkg::S_DUMP && !dp_status.cursor_zero |=> state == ise_pkg::S_DUMP)
    else $error("dump ended before the bottom entry");

  a_one_result_per_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ise_pkg::S_SWAP_RD2 || state == ise_pkg::S_SWAP_WR1) |-> !cmd.res_load)
    else $error("swap result issued before both writes");

endmodule
